// ----- rtl/bertlv_pkg.sv -----
// types, codes and state layout shared by the ber tlv stream decoder
`default_nettype none
package bertlv_pkg;

   typedef enum logic [2:0] {
      PH_IDENT    = 3'd0,
      PH_TAG_LONG = 3'd1,
      PH_LEN_HEAD = 3'd2,
      PH_LEN_LONG = 3'd3,
      PH_VALUE    = 3'd4,
      PH_HALT     = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_VALUE  = 2'd1,
      KIND_ERROR  = 2'd2,
      KIND_END    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ERR_TAG_TRUNC   = 3'd0,
      ERR_TAG_OVF     = 3'd1,
      ERR_NO_LEN      = 3'd2,
      ERR_LEN_LARGE   = 3'd3,
      ERR_LEN_OVF     = 3'd4,
      ERR_LEN_TRUNC   = 3'd5,
      ERR_VALUE_TRUNC = 3'd6
   } err_type;

   localparam logic [4:0] TAG_LONG_MARK = 5'h1F;
   localparam logic [2:0] MAX_LEN_BYTES = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_end;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  class_bits;
      logic [31:0] tag_number;
      logic [31:0] value_length;
      logic        indefinite;
      logic [7:0]  value_byte;
      logic        last;
      logic [2:0]  error_code;
   } rsp_type;

   typedef struct packed {
      phase_type   phase;
      logic [2:0]  class_hold;
      logic [31:0] tag_acc;
      logic [31:0] len_acc;
      logic [2:0]  len_left;
      logic [31:0] value_left;
      logic        skip_object;
   } state_type;

endpackage
`default_nettype wire

// ----- rtl/ber_tlv_stream_decoder_core.sv -----
// top level of the ber tlv stream decoder: beat registers, parse state and result register
`default_nettype none
// Parses a BER byte stream, one byte per req beat, and returns headers, value bytes with a
// last mark, clean-end markers and error codes on rsp. One byte is taken every clock cycle
// as long as rsp is not stalled. Each accepted byte waits in the input register until the
// result register is free or draining; its result (if any) is then registered there and
// shows on rsp. The rate is set by the combinational parse step that updates the header
// state from each byte. A stalled result holds one byte in the input register, then req
// stalls. After any error the block produces nothing more until reset.
module ber_tlv_stream_decoder_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  bertlv_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output bertlv_pkg::rsp_type rsp_data
);
   import bertlv_pkg::*;

   logic      in_valid_ff;
   logic      in_valid_in;
   req_type   in_data_ff;
   state_type state_ff;
   state_type state_in;
   state_type step_state;
   logic      step_emit;
   rsp_type   step_rsp;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   rsp_type   rsp_data_ff;
   logic      process;

   bertlv_step u_step (
      .state_cur (state_ff),
      .beat      (in_data_ff),
      .state_nxt (step_state),
      .emit      (step_emit),
      .rsp       (step_rsp)
   );

   // a held byte moves on once the result register is free or draining
   assign process   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !process;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else if (process) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      state_in     = process ? step_state : state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (process) begin
         rsp_valid_in = step_emit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{phase: PH_IDENT, default: '0};
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (process) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_HALT |=> state_ff.phase == PH_HALT)
      else $error("halt state left without reset");

   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      process && state_ff.phase == PH_HALT |=> !rsp_valid_ff)
      else $error("result produced while halted");

   a_value_count: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_VALUE |-> state_ff.value_left != 32'd0)
      else $error("value phase with no bytes left");

   a_len_count: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_LEN_LONG |->
         state_ff.len_left != 3'd0 && state_ff.len_left <= MAX_LEN_BYTES)
      else $error("length byte count out of range");

   a_indef_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.kind == KIND_HEADER && rsp_data_ff.indefinite
         |-> rsp_data_ff.value_length == 32'd0)
      else $error("indefinite header with nonzero length");
`endif

endmodule
`default_nettype wire

// ----- rtl/bertlv_step.sv -----
// next-state and result logic for one stream byte
`default_nettype none
module bertlv_step (
   input  bertlv_pkg::state_type state_cur,
   input  bertlv_pkg::req_type   beat,
   output bertlv_pkg::state_type state_nxt,
   output logic                  emit,
   output bertlv_pkg::rsp_type   rsp
);
   import bertlv_pkg::*;

   logic        do_fin;
   logic [31:0] fin_len;
   logic        fin_indef;
   logic        do_err;
   err_type     err_code;
   logic        skip_hdr;
   logic [7:0]  b;
   logic [31:0] len_shift;
   logic [2:0]  len_left_dec;
   logic [31:0] value_left_dec;

   assign b              = beat.data_byte;
   assign skip_hdr       = (state_cur.class_hold == 3'd0) && (state_cur.tag_acc == 32'd0);
   assign len_shift      = {state_cur.len_acc[23:0], b};
   assign len_left_dec   = state_cur.len_left - 3'd1;
   assign value_left_dec = state_cur.value_left - 32'd1;

   always_comb begin
      state_nxt = state_cur;
      emit      = 1'b0;
      rsp       = '0;
      do_fin    = 1'b0;
      fin_len   = 32'd0;
      fin_indef = 1'b0;
      do_err    = 1'b0;
      err_code  = ERR_TAG_TRUNC;

      case (state_cur.phase)
         PH_IDENT: begin
            if (beat.stream_end) begin
               emit     = 1'b1;
               rsp.kind = KIND_END;
            end else begin
               state_nxt.class_hold = b[7:5];
               if (b[4:0] != TAG_LONG_MARK) begin
                  state_nxt.tag_acc = {27'd0, b[4:0]};
                  state_nxt.phase   = PH_LEN_HEAD;
               end else begin
                  state_nxt.tag_acc = 32'd0;
                  state_nxt.phase   = PH_TAG_LONG;
               end
            end
         end
         PH_TAG_LONG: begin
            if (beat.stream_end) begin
               do_err   = 1'b1;
               err_code = ERR_TAG_TRUNC;
            end else if (state_cur.tag_acc[31:24] != 8'd0) begin
               do_err   = 1'b1;
               err_code = ERR_TAG_OVF;
            end else begin
               state_nxt.tag_acc = {state_cur.tag_acc[24:0], b[6:0]};
               if (!b[7]) begin
                  state_nxt.phase = PH_LEN_HEAD;
               end
            end
         end
         PH_LEN_HEAD: begin
            if (beat.stream_end) begin
               do_err   = 1'b1;
               err_code = ERR_NO_LEN;
            end else if (!b[7]) begin
               do_fin  = 1'b1;
               fin_len = {24'd0, b};
            end else if (b[6:0] == 7'd0) begin
               do_fin    = 1'b1;
               fin_indef = 1'b1;
            end else if (b[6:0] > {4'd0, MAX_LEN_BYTES}) begin
               do_err   = 1'b1;
               err_code = ERR_LEN_LARGE;
            end else begin
               state_nxt.len_acc  = 32'd0;
               state_nxt.len_left = b[2:0];
               state_nxt.phase    = PH_LEN_LONG;
            end
         end
         PH_LEN_LONG: begin
            // overflow check comes before the truncation check
            if (state_cur.len_acc[31:24] != 8'd0) begin
               do_err   = 1'b1;
               err_code = ERR_LEN_OVF;
            end else if (beat.stream_end) begin
               do_err   = 1'b1;
               err_code = ERR_LEN_TRUNC;
            end else begin
               state_nxt.len_acc  = len_shift;
               state_nxt.len_left = len_left_dec;
               if (len_left_dec == 3'd0) begin
                  do_fin  = 1'b1;
                  fin_len = len_shift;
               end
            end
         end
         PH_VALUE: begin
            if (beat.stream_end) begin
               do_err   = 1'b1;
               err_code = ERR_VALUE_TRUNC;
            end else begin
               state_nxt.value_left = value_left_dec;
               if (value_left_dec == 32'd0) begin
                  state_nxt.phase = PH_IDENT;
               end
               if (!state_cur.skip_object) begin
                  emit           = 1'b1;
                  rsp.kind       = KIND_VALUE;
                  rsp.value_byte = b;
                  rsp.last       = (value_left_dec == 32'd0);
               end
            end
         end
         default: begin
            state_nxt.phase = PH_HALT;
         end
      endcase

      if (do_err) begin
         state_nxt.phase = PH_HALT;
         emit            = 1'b1;
         rsp             = '0;
         rsp.kind        = KIND_ERROR;
         rsp.error_code  = err_code;
      end

      if (do_fin) begin
         // universal end-of-contents is swallowed with its contents
         state_nxt.skip_object = skip_hdr;
         state_nxt.value_left  = fin_len;
         state_nxt.phase       = (fin_len != 32'd0) ? PH_VALUE : PH_IDENT;
         if (!skip_hdr) begin
            emit             = 1'b1;
            rsp.kind         = KIND_HEADER;
            rsp.class_bits   = state_cur.class_hold;
            rsp.tag_number   = state_cur.tag_acc;
            rsp.value_length = fin_len;
            rsp.indefinite   = fin_indef;
         end
      end
   end

endmodule
`default_nettype wire
